// File: rtl/sorted_table_insert_search_macros.svh
// Assertion macros for the checks in the top-level sorted_table_insert_search module.
`ifndef SORTED_TABLE_INSERT_SEARCH_MACROS_SVH
`define SORTED_TABLE_INSERT_SEARCH_MACROS_SVH

// Checked only while the block is out of reset.
`define STI_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("sorted table check failed");

// Checked at every edge, reset included.
`define STI_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) (prop)) \
        else $error("sorted table reset check failed");

`endif

// File: rtl/sti_pkg.sv
package sti_pkg;

    localparam int CAPACITY  = 256;
    localparam int KEY_WIDTH = 32;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = IDX_W + 1;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_FIND   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_COMPARE,
        ST_SHIFT,
        ST_PROBE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic gt;
        logic eq;
    } cmp_res_t;

    typedef struct packed {
        logic                 wr_en;
        logic [IDX_W-1:0]     wr_addr;
        logic [KEY_WIDTH-1:0] wr_data;
        logic [IDX_W-1:0]     rd_addr;
    } mem_req_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [IDX_W-1:0] index;
        logic             found;
        logic             status;
    } result_t;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } ctrl_stat_t;

endpackage

// File: rtl/sorted_table_insert_search.sv
// Sorted key table with binary-search insert and find.
// Input words arrive on s_tvalid/s_tready: s_tuser selects the operation (0 insert,
// 1 find) and s_tdata carries the key. One result word per input word leaves on
// m_tvalid/m_tready with status, found flag, slot index and entry count.
// The compare mode (0 unsigned, 1 two's complement) is written on cfg_valid/cfg_data;
// write it only while no word is in flight.
// One word is handled at a time and s_tready stays low while it runs. A binary search
// passes through ST_SEARCH and ST_COMPARE for each probe through the table memory,
// whose read port is registered. An insert then moves every entry at or above its slot
// up by one, one entry per cycle through the single read and write port.
// An insert into a full table skips the search and is answered with status 1.
// s_tready rises again in the same cycle that the previous result appears on m_tvalid.
// Reset clears the entry count and the compare mode; no memory clearing is needed.
// The result sits in an output register, so the next word is accepted while it waits.
// If the receiver stalls, the following result is held back and the block waits.
module sorted_table_insert_search
    import sti_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // key [31:0]
    input  logic [0:0]  s_tuser,    // op [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // status [0], found [1], index [9:2], count [18:10]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_data    // compare_signed [0]
);

`include "sorted_table_insert_search_macros.svh"

    logic                 cmp_signed_reg;
    logic                 m_tvalid_reg;
    result_t              out_reg;
    logic                 out_free;
    logic [KEY_WIDTH-1:0] key;
    logic [KEY_WIDTH-1:0] rd_data;
    mem_req_t             mem_req;
    result_t              result;
    ctrl_stat_t           stat;
    cmp_res_t             cmp;
    logic                 refused_clean;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = stat.idle;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmp_signed_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                cmp_signed_reg <= cfg_data[0];
            end
            if (stat.res_valid) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
        if (stat.res_valid) begin
            out_reg <= result;
        end
    end

    sti_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_tvalid && stat.idle),
        .start_op  (s_tuser[0]),
        .start_key (s_tdata[KEY_WIDTH-1:0]),
        .out_free  (out_free),
        .cmp       (cmp),
        .rd_data   (rd_data),
        .key       (key),
        .mem_req   (mem_req),
        .result    (result),
        .stat      (stat)
    );

    sti_cmp u_cmp (
        .signed_mode (cmp_signed_reg),
        .key_a       (key),
        .key_b       (rd_data),
        .res         (cmp)
    );

    sti_store u_store (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, out_reg.count, out_reg.index, out_reg.found, out_reg.status};

    assign refused_clean = !out_reg.found && out_reg.index == '0
                           && out_reg.count == CNT_W'(CAPACITY);

    `STI_ASSERT(a_count_bound, m_tvalid_reg |-> out_reg.count <= CNT_W'(CAPACITY))
    `STI_ASSERT(a_refused_clean, (m_tvalid_reg && out_reg.status) |-> refused_clean)
    `STI_ASSERT(a_busy_no_result, (stat.res_valid) |-> (!s_tready && out_free))
    `STI_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> !m_tvalid)

endmodule

// File: rtl/sti_store.sv
module sti_store
    import sti_pkg::*;
(
    input  logic                 aclk,
    input  mem_req_t             req,
    output logic [KEY_WIDTH-1:0] rd_data
);

    logic [KEY_WIDTH-1:0] mem [CAPACITY];
    logic [KEY_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_data_reg <= mem[req.rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/sti_cmp.sv
module sti_cmp
    import sti_pkg::*;
(
    input  logic                 signed_mode,
    input  logic [KEY_WIDTH-1:0] key_a,
    input  logic [KEY_WIDTH-1:0] key_b,
    output cmp_res_t             res
);

    logic [KEY_WIDTH-1:0] ord_a;
    logic [KEY_WIDTH-1:0] ord_b;
    logic [KEY_WIDTH-1:0] sign_flip;

    // Flipping the sign bit maps two's complement order onto unsigned order.
    assign sign_flip = {signed_mode, {(KEY_WIDTH-1){1'b0}}};
    assign ord_a     = key_a ^ sign_flip;
    assign ord_b     = key_b ^ sign_flip;
    assign res.gt    = ord_a > ord_b;
    assign res.eq    = key_a == key_b;

endmodule

// File: rtl/sti_ctrl.sv
module sti_ctrl
    import sti_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic                 start_op,
    input  logic [KEY_WIDTH-1:0] start_key,
    input  logic                 out_free,
    input  cmp_res_t             cmp,
    input  logic [KEY_WIDTH-1:0] rd_data,
    output logic [KEY_WIDTH-1:0] key,
    output mem_req_t             mem_req,
    output result_t              result,
    output ctrl_stat_t           stat
);

    state_t               state_reg, state_next;
    logic                 op_reg, op_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic [CNT_W-1:0]     left_reg, left_next;
    logic [CNT_W-1:0]     right_reg, right_next;
    logic [CNT_W-1:0]     mid_reg, mid_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic [IDX_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                 pend_reg, pend_next;
    logic [IDX_W-1:0]     pend_addr_reg, pend_addr_next;
    result_t              res_reg, res_next;

    logic [CNT_W:0]       mid_sum;
    logic [CNT_W-1:0]     mid;
    logic                 full;

    assign mid_sum = {1'b0, left_reg} + {1'b0, right_reg};
    assign mid     = mid_sum[CNT_W:1];
    assign full    = cnt_reg == CNT_W'(CAPACITY);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
        end
        op_reg        <= op_next;
        key_reg       <= key_next;
        left_reg      <= left_next;
        right_reg     <= right_next;
        mid_reg       <= mid_next;
        n_reg         <= n_next;
        rd_idx_reg    <= rd_idx_next;
        pend_addr_reg <= pend_addr_next;
        res_reg       <= res_next;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = (start_op == OP_INSERT && full) ? ST_DONE : ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (left_reg < right_reg) begin
                    state_next = ST_COMPARE;
                end else if (op_reg == OP_INSERT) begin
                    state_next = ST_SHIFT;
                end else if (left_reg < cnt_reg) begin
                    state_next = ST_PROBE;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_COMPARE: state_next = ST_SEARCH;
            ST_SHIFT: begin
                if (n_reg == '0 && !pend_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_PROBE: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        op_next         = op_reg;
        key_next        = key_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        mid_next        = mid_reg;
        cnt_next        = cnt_reg;
        n_next          = n_reg;
        rd_idx_next     = rd_idx_reg;
        pend_next       = pend_reg;
        pend_addr_next  = pend_addr_reg;
        res_next        = res_reg;
        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = IDX_W'(pend_addr_reg + IDX_W'(1));
        mem_req.wr_data = key_reg;
        mem_req.rd_addr = rd_idx_reg;
        stat.idle       = 1'b0;
        stat.res_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                stat.idle        = 1'b1;
                op_next          = start_op;
                key_next         = start_key;
                left_next        = '0;
                right_next       = cnt_reg;
                pend_next        = 1'b0;
                res_next.count   = cnt_reg;
                res_next.index   = '0;
                res_next.found   = 1'b0;
                res_next.status  = start_op == OP_INSERT && full;
            end
            ST_SEARCH: begin
                mid_next        = mid;
                mem_req.rd_addr = mid[IDX_W-1:0];
                if (!(left_reg < right_reg)) begin
                    mem_req.rd_addr = left_reg[IDX_W-1:0];
                    n_next          = cnt_reg - left_reg;
                    rd_idx_next     = IDX_W'(cnt_reg - CNT_W'(1));
                end
            end
            ST_COMPARE: begin
                if (cmp.gt) begin
                    left_next = mid_reg + CNT_W'(1);
                end else begin
                    right_next = mid_reg;
                end
            end
            ST_SHIFT: begin
                if (pend_reg) begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_data = rd_data;
                end
                if (n_reg != '0) begin
                    mem_req.rd_addr = rd_idx_reg;
                    rd_idx_next     = rd_idx_reg - IDX_W'(1);
                    n_next          = n_reg - CNT_W'(1);
                    pend_next       = 1'b1;
                    pend_addr_next  = rd_idx_reg;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = left_reg[IDX_W-1:0];
                        mem_req.wr_data = key_reg;
                        cnt_next        = cnt_reg + CNT_W'(1);
                        res_next.count  = cnt_reg + CNT_W'(1);
                        res_next.index  = left_reg[IDX_W-1:0];
                    end
                end
            end
            ST_PROBE: begin
                res_next.found = cmp.eq;
                res_next.index = cmp.eq ? left_reg[IDX_W-1:0] : '0;
            end
            ST_DONE: begin
                stat.res_valid = out_free;
            end
            default: ;
        endcase
    end

    assign key    = key_reg;
    assign result = res_reg;

endmodule
